@@ sv/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial line editor package
// Shared types and byte codes for the serial console line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;

   localparam logic [BYTE_W-1:0] BYTE_CR      = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_ESC     = 8'h1B;
   localparam logic [BYTE_W-1:0] BYTE_O       = 8'h4F;
   localparam logic [BYTE_W-1:0] BYTE_BRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] BYTE_M       = 8'h4D;
   localparam logic [BYTE_W-1:0] BYTE_BS      = 8'h08;
   localparam logic [BYTE_W-1:0] BYTE_DEL     = 8'h7F;
   localparam logic [BYTE_W-1:0] BYTE_SPACE   = 8'h20;

   typedef enum logic [1:0] {
      KIND_ECHO,
      KIND_LINE,
      KIND_END,
      KIND_OVERFLOW
   } sle_kind_type;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_FIRST,
      MODE_SECOND
   } sle_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ECHO,
      S_OVF,
      S_BS,
      S_LINE_OUT,
      S_END
   } sle_state_type;

   typedef struct packed {
      sle_kind_type      kind;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  line_length;
      logic              last;
   } sle_result_type;

endpackage

`default_nettype wire

@@ sv/sle_line_mem.sv @@
// ----------------------------------------------------------------------------
// Line store memory
// One write port, one read port, registered read data (valid the cycle after rd_en).
// ----------------------------------------------------------------------------
`default_nettype none

module sle_line_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] line_mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// Line editor control
// Escape decoding, character count and result sequencing over the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl #(
   parameter int LINE_DEPTH = 64,
   parameter int CW         = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   mem_we,
   output logic [CW-1:0]          mem_waddr,
   output logic [7:0]             mem_wdata,
   output logic                   mem_re,
   output logic [CW-1:0]          mem_raddr,
   input  logic [7:0]             mem_rdata,
   input  logic                   out_free,
   output logic                   rsp_load,
   output sle_pkg::sle_result_type rsp_item
);

   import sle_pkg::*;

   localparam logic [CW-1:0] CNT_LAST = CW'(LINE_DEPTH - 1);

   sle_state_type state_ff, state_in;
   sle_mode_type  mode_ff, mode_in;
   logic          was_o_ff, was_o_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    byte_ff, byte_in;
   logic          ovf_ff, ovf_in;
   logic [1:0]    bs_step_ff, bs_step_in;

   logic          accept;
   logic          esc_m, esc_lead, esc_start, plain;
   logic          act_line, act_bs, act_store;
   logic [CW:0]   idx_nx;
   logic          more;

   // Byte decode, valid only when an item is taken
   always_comb begin
      esc_m     = (mode_ff == MODE_SECOND) && was_o_ff && (req_rx_byte == BYTE_M);
      esc_lead  = !esc_m && (mode_ff == MODE_FIRST) &&
                  ((req_rx_byte == BYTE_O) || (req_rx_byte == BYTE_BRACKET));
      esc_start = !esc_m && !esc_lead && (req_rx_byte == BYTE_ESC);
      plain     = !esc_m && !esc_lead && !esc_start;
      act_line  = esc_m || (plain && (req_rx_byte == BYTE_CR));
      act_bs    = plain && ((req_rx_byte == BYTE_BS) || (req_rx_byte == BYTE_DEL));
      act_store = plain && !act_line && !act_bs;
      idx_nx    = {1'b0, idx_ff} + (CW+1)'(1);
      more      = idx_nx < {1'b0, len_ff};
   end

   // Next state
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      was_o_in   = was_o_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      byte_in    = byte_ff;
      ovf_in     = ovf_ff;
      bs_step_in = bs_step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_rx_byte;
               if (!esc_m && (mode_ff == MODE_FIRST)) begin
                  was_o_in = (req_rx_byte == BYTE_O);
               end
               if (esc_lead) begin
                  mode_in = MODE_SECOND;
               end else if (esc_start) begin
                  mode_in = MODE_FIRST;
               end else begin
                  mode_in = MODE_PLAIN;
               end
               if (act_line) begin
                  len_in   = count_ff;
                  count_in = '0;
                  idx_in   = '0;
                  state_in = (count_ff == '0) ? S_END : S_LINE_OUT;
               end else if (act_bs) begin
                  if (count_ff != '0) begin
                     count_in   = count_ff - CW'(1);
                     bs_step_in = 2'd0;
                     state_in   = S_BS;
                  end
               end else if (act_store) begin
                  ovf_in   = (count_ff == CNT_LAST);
                  count_in = (count_ff == CNT_LAST) ? '0 : count_ff + CW'(1);
                  state_in = S_ECHO;
               end
            end
         end
         S_ECHO: begin
            if (out_free) begin
               state_in = ovf_ff ? S_OVF : S_IDLE;
            end
         end
         S_OVF: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_BS: begin
            if (out_free) begin
               bs_step_in = bs_step_ff + 2'd1;
               if (bs_step_ff == 2'd2) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_LINE_OUT: begin
            if (out_free) begin
               if (more) begin
                  idx_in = idx_nx[CW-1:0];
               end else begin
                  state_in = S_END;
               end
            end
         end
         S_END: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      accept    = req_valid && !req_stall;
      mem_we    = accept && act_store;
      mem_waddr = count_ff;
      mem_wdata = req_rx_byte;
      mem_re    = 1'b0;
      mem_raddr = '0;
      rsp_load  = 1'b0;
      rsp_item  = '{kind: KIND_ECHO, data_byte: '0, line_length: '0, last: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (accept && act_line) begin
               mem_re = 1'b1;
            end
         end
         S_ECHO: begin
            rsp_load           = out_free;
            rsp_item.data_byte = byte_ff;
            rsp_item.last      = !ovf_ff;
         end
         S_OVF: begin
            rsp_load      = out_free;
            rsp_item.kind = KIND_OVERFLOW;
            rsp_item.last = 1'b1;
         end
         S_BS: begin
            rsp_load           = out_free;
            rsp_item.data_byte = (bs_step_ff == 2'd1) ? BYTE_SPACE : BYTE_BS;
            rsp_item.last      = (bs_step_ff == 2'd2);
         end
         S_LINE_OUT: begin
            rsp_load           = out_free;
            rsp_item.kind      = KIND_LINE;
            rsp_item.data_byte = mem_rdata;
            mem_re             = out_free && more;
            mem_raddr          = idx_nx[CW-1:0];
         end
         S_END: begin
            rsp_load             = out_free;
            rsp_item.kind        = KIND_END;
            rsp_item.line_length = LEN_W'(len_ff);
            rsp_item.last        = 1'b1;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mode_ff    <= MODE_PLAIN;
         was_o_ff   <= 1'b0;
         count_ff   <= '0;
         idx_ff     <= '0;
         ovf_ff     <= 1'b0;
         bs_step_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         was_o_ff   <= was_o_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         ovf_ff     <= ovf_in;
         bs_step_ff <= bs_step_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      byte_ff <= byte_in;
   end

`ifndef SYNTH
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("line store read and write in the same cycle");

   a_idx_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINE_OUT) |-> (idx_ff < len_ff))
      else $error("line readout index beyond line length");

   a_overflow_path: assert property (@(posedge clock) disable iff (reset)
      (accept && act_store && (count_ff == CNT_LAST)) |=>
      ((state_ff == S_ECHO) && ovf_ff && (count_ff == '0)))
      else $error("full store did not raise overflow");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded into occupied output register");
`endif

endmodule

`default_nettype wire

@@ sv/serial_line_editor_unit.sv @@
// ----------------------------------------------------------------------------
// Serial line editor unit
// Line editor for a serial console: echo, backspace, escape handling and
// line readout from an on-chip line store.
// ----------------------------------------------------------------------------
// Usage:
//   req channel  - one received terminal byte per item (req_rx_byte).
//   rsp channel  - result items: kind, data_byte, line_length, last. The
//                  final result caused by one input byte carries last = 1.
//   The block takes one byte at a time; req_stall is high while results of
//   the previous byte are still being produced.
// Result sequences and throughput:
//   Swallowed escape bytes and backspace on an empty line: no result.
//   Ordinary byte: an echo item, then an overflow item when the byte fills the store.
//   Backspace: 3 echo items (BS, space, BS).
//   Line end: n stored bytes then the end marker, n + 1 items, one per cycle
//   while the receiver takes them, set by the single read port of the line
//   store (read data registered, next address issued as each byte leaves).
// Reset: synchronous, clears escape state and character count; the line
//   store needs no clearing since only written entries are read back.
// Receiver stall: the output register holds its item; the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_editor_unit #(
   parameter int LINE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [5:0] rsp_line_length,
   output logic       rsp_last
);

   import sle_pkg::*;

   localparam int CW = $clog2(LINE_DEPTH);

   // Line store port signals
   logic          mem_we;
   logic [CW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;
   logic [CW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   // Output register: one item, loaded by the sequencer when free
   logic           out_free;
   logic           rsp_load;
   sle_result_type rsp_item;
   sle_result_type rsp_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   sle_line_mem #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (CW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sle_ctrl #(
      .LINE_DEPTH (LINE_DEPTH),
      .CW         (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_item    (rsp_item)
   );

   // Free when empty or when the held item leaves this cycle
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload unless a new item is loaded
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff <= rsp_item;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_item_ff.kind;
   assign rsp_data_byte   = rsp_item_ff.data_byte;
   assign rsp_line_length = rsp_item_ff.line_length;
   assign rsp_last        = rsp_item_ff.last;

endmodule

`default_nettype wire
